// File: src/assert_macros.svh
// Assertion macros used by the ring buffer controller.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/orb_pkg.sv
// Shared types and constants for the overwriting ring buffer.
// No dependencies; every other file but assert_macros.svh imports this package.
package orb_pkg;

   // Parameter defaults
   localparam int DEPTH_DEF      = 16;
   localparam int ELEM_WIDTH_DEF = 16;

   // Fixed widths of the channel fields
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 16;
   localparam int OFFSET_W = 8;
   localparam int COUNT_W  = 5;

   // Slot index width that covers the largest supported depth (128)
   localparam int SLOT_IDX_W = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH     = 3'd0,
      ACT_POP      = 3'd1,
      ACT_PEEK_OLD = 3'd2,
      ACT_PEEK_NEW = 3'd3,
      ACT_GET      = 3'd4,
      ACT_CLEAR    = 3'd5
   } action_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic                  clear;
      logic                  rotate;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      logic [SLOT_IDX_W-1:0] rd_idx;
   } cell_cmd_type;

endpackage

// File: src/orb_if.sv
// Valid/ready channel interfaces for the ring buffer request and response.
// Depends on orb_pkg for the field widths.
interface orb_req_if;
   import orb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [VALUE_W-1:0]         push_value;
   logic signed [OFFSET_W-1:0] offset;

   modport source (output valid, action, push_value, offset, input ready);
   modport sink   (input valid, action, push_value, offset, output ready);
endinterface

interface orb_rsp_if;
   import orb_pkg::*;

   logic               valid;
   logic               ready;
   logic               ok;
   logic [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0] fill_count;

   modport source (output valid, ok, read_value, fill_count, input ready);
   modport sink   (input valid, ok, read_value, fill_count, output ready);
endinterface

// File: src/orb_cell.sv
// One storage cell of the ring buffer: holds one slot, relative to the oldest entry.
// Depends on orb_pkg for the command struct.
module orb_cell #(
   parameter int ELEM_WIDTH = orb_pkg::ELEM_WIDTH_DEF,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  orb_pkg::cell_cmd_type cmd,
   input  logic [ELEM_WIDTH-1:0] value_in,
   input  logic [ELEM_WIDTH-1:0] nbr_data,
   output logic [ELEM_WIDTH-1:0] data_out,
   output logic [ELEM_WIDTH-1:0] rd_data
);
   import orb_pkg::*;

   logic [ELEM_WIDTH-1:0] slot_ff;
   logic [ELEM_WIDTH-1:0] slot_in;

   // Take the neighbor on rotate, then the write, then clear wins
   always_comb begin
      slot_in = cmd.rotate ? nbr_data : slot_ff;
      if (cmd.wr_en && (cmd.wr_idx == SLOT_IDX_W'(IDX))) begin
         slot_in = value_in;
      end
      if (cmd.clear) begin
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   // Drive the slot onto the read bus only when selected
   assign data_out = slot_ff;
   assign rd_data  = (cmd.rd_idx == SLOT_IDX_W'(IDX)) ? slot_ff : '0;

endmodule

// File: src/orb_ctrl.sv
// Controller of the ring buffer: keeps the fill count and decodes each action
// into a cell command and the response status. Depends on orb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orb_ctrl #(
   parameter int DEPTH = orb_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic [orb_pkg::ACTION_W-1:0]        action,
   input  logic signed [orb_pkg::OFFSET_W-1:0] offset,
   output orb_pkg::cell_cmd_type               cmd,
   output logic                                ok,
   output logic                                rd_zero,
   output logic [$clog2(DEPTH+1)-1:0]          count_next
);
   import orb_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             empty;
   logic             in_range;
   logic [CMP_W-1:0] off_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             clear;
   logic             rotate;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   // Decode the action against the current fill count
   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      off_ext  = CMP_W'($unsigned(offset));
      cnt_ext  = CMP_W'(count_ff);
      in_range = !offset[OFFSET_W-1] && (off_ext < cnt_ext);

      clear    = 1'b0;
      rotate   = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = '0;
      rd_idx   = '0;
      ok       = 1'b0;
      rd_zero  = 1'b1;
      count_in = count_ff;

      case (action)
         ACT_PUSH: begin
            wr_en = 1'b1;
            ok    = 1'b1;
            if (full) begin
               // Drop the oldest entry: rotate and land the new one at the end
               rotate = 1'b1;
               wr_idx = IDX_W'(DEPTH - 1);
            end else begin
               wr_idx   = count_ff[IDX_W-1:0];
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP: begin
            rd_zero = 1'b0;
            if (!empty) begin
               rotate   = 1'b1;
               ok       = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_PEEK_OLD: begin
            rd_zero = 1'b0;
            ok      = !empty;
         end
         ACT_PEEK_NEW: begin
            rd_zero = 1'b0;
            if (!empty) begin
               rd_idx = IDX_W'(count_ff - 1'b1);
               ok     = 1'b1;
            end
         end
         ACT_GET: begin
            rd_zero = 1'b0;
            if (in_range) begin
               rd_idx = offset[IDX_W-1:0];
               ok     = 1'b1;
            end
         end
         ACT_CLEAR: begin
            clear    = 1'b1;
            ok       = 1'b1;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Gate state changes with the handshake
   always_comb begin
      cmd.clear  = fire && clear;
      cmd.rotate = fire && rotate;
      cmd.wr_en  = fire && wr_en;
      cmd.wr_idx = SLOT_IDX_W'(wr_idx);
      cmd.rd_idx = SLOT_IDX_W'(rd_idx);
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   `ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "fill count above depth")
   `ASSERT_NEXT(a_clear_empties, fire && (action == ACT_CLEAR), count_ff == '0, "clear left entries")
   `ASSERT_NEXT(a_push_grows, fire && (action == ACT_PUSH) && !full, count_ff == $past(count_ff) + 1'b1, "push did not grow count")
   `ASSERT_NEXT(a_idle_holds, !fire, $stable(count_ff), "count moved without an item")
   `ASSERT_IMPLY(a_rotate_nonempty, cmd.rotate, !empty, "rotate on an empty buffer")

endmodule

// File: src/overwriting_ring_buffer.sv
// Overwriting ring buffer: a row of DEPTH cells kept so that cell 0 always holds the
// oldest entry. One item is taken per clock cycle; its response is held in the output
// register, and the next item can be taken in the same cycle as that response is drained,
// so the sustained rate is one item per cycle unless the response side stalls. Every
// action, including clear and a push that drops the oldest entry, updates all cells at
// once (a pop or a full push shifts the row by one cell). Reset zeroes every slot at
// once; there is no clearing pass.
// Depends on orb_pkg, orb_if, orb_cell and orb_ctrl.
module overwriting_ring_buffer #(
   parameter int DEPTH      = orb_pkg::DEPTH_DEF,
   parameter int ELEM_WIDTH = orb_pkg::ELEM_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   orb_req_if.sink    req_chan,
   orb_rsp_if.source  rsp_chan
);
   import orb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                          fire;
   cell_cmd_type                  cmd;
   logic                          ok;
   logic                          rd_zero;
   logic [CNT_W-1:0]              count_next;
   logic [ELEM_WIDTH+VALUE_W-1:0] value_wide;
   logic [ELEM_WIDTH-1:0]         value;
   logic [ELEM_WIDTH-1:0]         slot_q  [DEPTH];
   logic [ELEM_WIDTH-1:0]         rd_part [DEPTH];
   logic [ELEM_WIDTH-1:0]         rd_or;
   logic [ELEM_WIDTH+VALUE_W-1:0] rd_wide;
   logic [CNT_W+COUNT_W-1:0]      fill_wide;

   logic               rsp_valid_ff;
   logic               ok_ff;
   logic [VALUE_W-1:0] read_value_ff;
   logic [COUNT_W-1:0] fill_count_ff;

   // Take an item whenever the output register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   // Fit the pushed value to the slot width
   assign value_wide = {{ELEM_WIDTH{1'b0}}, req_chan.push_value};
   assign value      = value_wide[ELEM_WIDTH-1:0];

   orb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .action     (req_chan.action),
      .offset     (req_chan.offset),
      .cmd        (cmd),
      .ok         (ok),
      .rd_zero    (rd_zero),
      .count_next (count_next)
   );

   // Row of cells, closed into a ring for rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      orb_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .IDX        (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .value_in (value),
         .nbr_data (slot_q[(i + 1) % DEPTH]),
         .data_out (slot_q[i]),
         .rd_data  (rd_part[i])
      );
   end

   // Combine the read bus; only the selected cell drives it
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | rd_part[i];
      end
   end

   assign rd_wide   = {{VALUE_W{1'b0}}, rd_or};
   assign fill_wide = {{COUNT_W{1'b0}}, count_next};

   // Hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         ok_ff         <= ok;
         read_value_ff <= rd_zero ? '0 : rd_wide[VALUE_W-1:0];
         fill_count_ff <= fill_wide[COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.read_value = read_value_ff;
   assign rsp_chan.fill_count = fill_count_ff;

endmodule
